// ----- hw/rtl/gfsq_pkg.sv -----
// ----------------------------------------------------------------------------
// Group fair-share ready queue package
// Shared widths, payload types, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package gfsq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned GROUPS_DEF      = 16;

  localparam int unsigned GROUP_W = 4;
  localparam int unsigned PID_W   = 24;
  localparam int unsigned SHARE_W = 8;

  localparam logic [SHARE_W-1:0] SHARE_RESET = 8'd100;

  typedef enum logic [0:0] {
    REQ_CREATE   = 1'b0,
    REQ_DISPATCH = 1'b1
  } req_type_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [GROUP_W-1:0] group_id;
    logic [PID_W-1:0]   process_id;
  } gfsq_req_t;

  typedef struct packed {
    logic               ok;
    logic [PID_W-1:0]   run_id;
    logic [GROUP_W-1:0] run_group;
    logic [SHARE_W-1:0] share;
  } gfsq_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_HEAD,
    ST_COUNT,
    ST_DIV1,
    ST_DIV2,
    ST_FINISH
  } gfsq_state_e;

  typedef struct packed {
    logic take;        // input channel ready
    logic check;       // evaluate request, read queue head
    logic head_read;   // read count of the head entry's group
    logic div_start;   // launch a division
    logic div_second;  // operands of the second division
    logic finish;      // commit state and load the result register
  } gfsq_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic fail;
    logic is_dispatch;
    logic div_busy;
    logic out_free;
  } gfsq_stat_t;

endpackage

// ----- hw/rtl/gfsq_chan_if.sv -----
// ----------------------------------------------------------------------------
// Group fair-share ready queue channel
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface gfsq_chan_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ----- hw/rtl/group_fair_share_ready_queue_unit.sv -----
// ----------------------------------------------------------------------------
// Group fair-share ready queue unit
// Ring-buffer ready queue of (group, process id) entries; dispatch reports
// the head entry and its share of the configured total.
//
//   channel   direction  payload                                 purpose
//   req_chan  in         req_type, group_id, process_id          create/dispatch
//   rsp_chan  out        ok, run_id, run_group, share            one per request
//   cfg_chan  in         share_total (8 bits)                    total share
//
// A create goes through the check and count states, a failing request only
// through the check. A successful dispatch runs two dependent memory reads and
// two 8-step restoring divisions in the shared divider.
// One request is in flight at a time; a new one is accepted while the
// previous result still waits in the output register.
// Reset empties the queue and clears all group counts, with no sweep.
// A stalled output holds the controller in its final state.
// ----------------------------------------------------------------------------
module group_fair_share_ready_queue_unit
  import gfsq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned GROUPS      = GROUPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gfsq_chan_if.sink   req_chan,
  gfsq_chan_if.source rsp_chan,
  gfsq_chan_if.sink   cfg_chan
);

  gfsq_cmd_t  cmd;
  gfsq_stat_t stat;

  gfsq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  gfsq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .GROUPS      (GROUPS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_chan (req_chan),
    .rsp_chan (rsp_chan),
    .cfg_chan (cfg_chan),
    .cmd_i    (cmd),
    .stat_o   (stat)
  );

endmodule

// ----- hw/rtl/gfsq_div.sv -----
// ----------------------------------------------------------------------------
// Group fair-share ready queue divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gfsq_div
  import gfsq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SHARE_W-1:0] dividend_i,
  input  logic [SHARE_W-1:0] divisor_i,
  output logic               busy_o,
  output logic [SHARE_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(SHARE_W);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SHARE_W-1:0] rem_q, quo_q, dsr_q;
  logic [SHARE_W:0]   shifted, trial;
  logic               take_bit;

  // The remainder stays below the divisor, so the trial difference fits in
  // one bit more than the operands and its top bit is the borrow.
  always_comb begin
    shifted  = {rem_q, quo_q[SHARE_W-1]};
    trial    = shifted - {1'b0, dsr_q};
    take_bit = ~trial[SHARE_W];
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(SHARE_W - 1);
    end else if (busy_q) begin
      step_d = step_q - STEP_W'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take_bit ? trial[SHARE_W-1:0] : shifted[SHARE_W-1:0];
      quo_q <= {quo_q[SHARE_W-2:0], take_bit};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ----- hw/rtl/gfsq_dp.sv -----
// ----------------------------------------------------------------------------
// Group fair-share ready queue datapath
// Queue memory, per-group count memory, pointers, share register, divider
// and the result register.
// ----------------------------------------------------------------------------
module gfsq_dp
  import gfsq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned GROUPS      = GROUPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gfsq_chan_if.sink   req_chan,
  gfsq_chan_if.source rsp_chan,
  gfsq_chan_if.sink   cfg_chan,
  input  gfsq_cmd_t   cmd_i,
  output gfsq_stat_t  stat_o
);

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned GIDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int unsigned DST_W  = $clog2(GROUPS + 1);
  localparam int unsigned GCMP_W = 8;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  gfsq_req_t          req_q;
  logic [SHARE_W-1:0] share_q;
  logic [PTR_W-1:0]   head_q, tail_q, head_next, tail_next;
  logic [DST_W-1:0]   distinct_q, distinct_d;
  logic               fail_q;
  logic               out_valid_q;
  gfsq_rsp_t          out_data_q, result;

  logic [PID_W-1:0]   id_mem  [QUEUE_DEPTH];
  logic [GROUP_W-1:0] grp_mem [QUEUE_DEPTH];
  logic [PID_W-1:0]   id_rd_q;
  logic [GROUP_W-1:0] grp_rd_q;

  logic [CNT_W-1:0]   cnt_mem [GROUPS];
  logic [GROUPS-1:0]  cnt_vld_q;
  logic [CNT_W-1:0]   cnt_rd_q;
  logic               cnt_vld_rd_q;

  logic               is_disp, grp_ok, fail_now, commit;
  logic [GIDX_W-1:0]  req_gidx, head_gidx, cnt_addr, upd_gidx;
  logic [CNT_W-1:0]   cnt_cur, cnt_new;
  logic [SHARE_W-1:0] dividend, divisor, quotient;
  logic               div_busy;

  always_comb begin
    head_next = (head_q == LAST_PTR) ? '0 : head_q + PTR_W'(1);
    tail_next = (tail_q == LAST_PTR) ? '0 : tail_q + PTR_W'(1);
    is_disp   = (req_q.req_type == REQ_DISPATCH);
    grp_ok    = GCMP_W'(req_q.group_id) < GCMP_W'(GROUPS);
    fail_now  = is_disp ? (head_q == tail_q) : ((tail_next == head_q) || !grp_ok);
    req_gidx  = GIDX_W'(req_q.group_id);
    head_gidx = GIDX_W'(grp_rd_q);
    cnt_addr  = cmd_i.head_read ? head_gidx : req_gidx;
    upd_gidx  = is_disp ? head_gidx : req_gidx;
    cnt_cur   = cnt_vld_rd_q ? cnt_rd_q : '0;
    cnt_new   = is_disp ? cnt_cur - CNT_W'(1) : cnt_cur + CNT_W'(1);
    commit    = cmd_i.finish && !fail_q;
    dividend  = cmd_i.div_second ? quotient : share_q;
    divisor   = cmd_i.div_second ? SHARE_W'(cnt_cur) : SHARE_W'(distinct_q);
  end

  // The distinct-group count follows each group count across zero.
  always_comb begin
    distinct_d = distinct_q;
    if (commit) begin
      if (!is_disp && (cnt_cur == '0)) begin
        distinct_d = distinct_q + DST_W'(1);
      end else if (is_disp && (cnt_cur == CNT_W'(1))) begin
        distinct_d = distinct_q - DST_W'(1);
      end
    end
  end

  always_comb begin
    result = '0;
    result.ok = !fail_q;
    if (!fail_q && is_disp) begin
      result.run_id    = id_rd_q;
      result.run_group = grp_rd_q;
      result.share     = quotient;
    end
  end

  gfsq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && req_chan.valid) begin
      req_q <= req_chan.data;
    end
    if (cmd_i.finish) begin
      out_data_q <= result;
    end
  end

  // Queue memory: write at the tail, registered read at the head.
  always_ff @(posedge clk_i) begin
    if (commit && !is_disp) begin
      id_mem[tail_q]  <= req_q.process_id;
      grp_mem[tail_q] <= req_q.group_id;
    end
    if (cmd_i.check) begin
      id_rd_q  <= id_mem[head_q];
      grp_rd_q <= grp_mem[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      cnt_mem[upd_gidx] <= cnt_new;
    end
    if (cmd_i.check || cmd_i.head_read) begin
      cnt_rd_q     <= cnt_mem[cnt_addr];
      cnt_vld_rd_q <= cnt_vld_q[cnt_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      share_q     <= SHARE_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      distinct_q  <= '0;
      fail_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_vld_q   <= '0;
    end else begin
      if (cfg_chan.valid) begin
        share_q <= cfg_chan.data;
      end
      if (cmd_i.check) begin
        fail_q <= fail_now;
      end
      if (commit) begin
        cnt_vld_q[upd_gidx] <= 1'b1;
        if (is_disp) begin
          head_q <= head_next;
        end else begin
          tail_q <= tail_next;
        end
      end
      distinct_q <= distinct_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (rsp_chan.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign req_chan.ready = cmd_i.take;
  assign cfg_chan.ready = 1'b1;
  assign rsp_chan.valid = out_valid_q;
  assign rsp_chan.data  = out_data_q;

  assign stat_o.in_valid    = req_chan.valid;
  assign stat_o.fail        = fail_now;
  assign stat_o.is_dispatch = is_disp;
  assign stat_o.div_busy    = div_busy;
  assign stat_o.out_free    = !out_valid_q || rsp_chan.ready;

  a_empty_no_groups: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == tail_q) == (distinct_q == '0))
    else $error("distinct group count disagrees with queue occupancy");

  a_head_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && is_disp |=> head_q != $past(head_q))
    else $error("successful dispatch did not advance the head");

  a_no_create_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && !is_disp |-> tail_next != head_q)
    else $error("create committed into a full queue");

endmodule

// ----- hw/rtl/gfsq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Group fair-share ready queue controller
// Sequences one request at a time through check and, unless it fails, lookup;
// a dispatch then runs two divisions. Every request ends in the finish state.
// ----------------------------------------------------------------------------
module gfsq_ctrl
  import gfsq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  gfsq_stat_t stat_i,
  output gfsq_cmd_t  cmd_o
);

  gfsq_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (stat_i.in_valid) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.fail) begin
          state_d = ST_FINISH;
        end else if (stat_i.is_dispatch) begin
          state_d = ST_HEAD;
        end else begin
          state_d = ST_COUNT;
        end
      end
      ST_HEAD: begin
        state_d = ST_COUNT;
      end
      ST_COUNT: begin
        state_d = stat_i.is_dispatch ? ST_DIV1 : ST_FINISH;
      end
      ST_DIV1: begin
        if (!stat_i.div_busy) begin
          state_d = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (!stat_i.div_busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.take       = (state_q == ST_IDLE);
    cmd_o.check      = (state_q == ST_CHECK);
    cmd_o.head_read  = (state_q == ST_HEAD);
    cmd_o.div_second = (state_q == ST_DIV1);
    cmd_o.div_start  = ((state_q == ST_COUNT) && stat_i.is_dispatch) ||
                       ((state_q == ST_DIV1) && !stat_i.div_busy);
    cmd_o.finish     = (state_q == ST_FINISH) && stat_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !stat_i.div_busy)
    else $error("divider still running while the controller is idle");

endmodule

// ----- tb/sv/gfsq_share_checker.sv -----
// ----------------------------------------------------------------------------
// Group fair-share ready queue checker
// Watches the request, result and share-total channels, keeps its own copy of
// the ready queue and group counts, predicts each result and compares it
// field by field with what the unit returns.
// ----------------------------------------------------------------------------
module gfsq_share_checker
  import gfsq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned GROUPS      = GROUPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gfsq_chan_if        req_if,
  gfsq_chan_if        rsp_if,
  gfsq_chan_if        cfg_if,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned created_o,
  output int unsigned dispatched_o,
  output int unsigned create_rejects_o,
  output int unsigned empty_rejects_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  logic [PID_W-1:0]   slot_pid   [QUEUE_DEPTH];
  logic [GROUP_W-1:0] slot_group [QUEUE_DEPTH];
  logic [GROUP_W-1:0] members    [GROUPS];
  logic [PTR_W-1:0]   head_slot;
  logic [PTR_W-1:0]   tail_slot;
  logic [SHARE_W-1:0] share_total;
  gfsq_rsp_t          awaited_replies [$];

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Applies one request to the queue copy and returns the result it causes.
  function automatic gfsq_rsp_t schedule_request(input gfsq_req_t r);
    gfsq_rsp_t          reply;
    logic [GROUP_W-1:0] hg;
    logic [GROUP_W-1:0] cnt;
    logic [SHARE_W-1:0] s;
    int unsigned        distinct;
    reply = '0;
    if (r.req_type == REQ_CREATE) begin
      if (ring_next(tail_slot) != head_slot && int'(r.group_id) < GROUPS) begin
        slot_pid[tail_slot]   = r.process_id;
        slot_group[tail_slot] = r.group_id;
        members[r.group_id]   = members[r.group_id] + 1'b1;
        tail_slot             = ring_next(tail_slot);
        reply.ok              = 1'b1;
        created_o++;
      end else begin
        create_rejects_o++;
      end
    end else if (head_slot == tail_slot) begin
      empty_rejects_o++;
    end else begin
      hg       = slot_group[head_slot];
      cnt      = members[hg];
      s        = share_total;
      distinct = 0;
      for (int g = 0; g < GROUPS; g++) begin
        if (members[g] != '0) distinct++;
      end
      // Both divisions truncate; the head entry is still counted in its group.
      if (distinct != 0) s = SHARE_W'(s / distinct);
      if (cnt != '0) begin
        s           = s / cnt;
        members[hg] = cnt - 1'b1;
      end
      reply.ok        = 1'b1;
      reply.run_id    = slot_pid[head_slot];
      reply.run_group = hg;
      reply.share     = s;
      head_slot       = ring_next(head_slot);
      dispatched_o++;
    end
    return reply;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      errors_o++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    gfsq_rsp_t want;
    if (!rst_ni) begin
      head_slot   = '0;
      tail_slot   = '0;
      share_total = SHARE_RESET;
      for (int g = 0; g < GROUPS; g++) members[g] = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        slot_pid[i]   = '0;
        slot_group[i] = '0;
      end
      awaited_replies.delete();
      errors_o         = 0;
      created_o        = 0;
      dispatched_o     = 0;
      create_rejects_o = 0;
      empty_rejects_o  = 0;
    end else begin
      // Results are checked before new requests so that an unexpected item
      // cannot be matched with a prediction made at the same edge.
      if (rsp_if.valid && rsp_if.ready) begin
        if (awaited_replies.size() == 0) begin
          errors_o++;
          $display("%0t: result with none expected, got %h", $time, rsp_if.data);
        end else begin
          want = awaited_replies.pop_front();
          check_field("ok", 32'(want.ok), 32'(rsp_if.data.ok));
          check_field("run_id", 32'(want.run_id), 32'(rsp_if.data.run_id));
          check_field("run_group", 32'(want.run_group), 32'(rsp_if.data.run_group));
          check_field("share", 32'(want.share), 32'(rsp_if.data.share));
        end
      end
      if (cfg_if.valid && cfg_if.ready) share_total = cfg_if.data;
      if (req_if.valid && req_if.ready) begin
        awaited_replies.push_back(schedule_request(req_if.data));
      end
    end
    pending_o = awaited_replies.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Group fair-share ready queue testbench
// Drives create and dispatch requests and share-total writes into the unit,
// first a directed sequence that empties, fills and overfills the queue,
// then randomized phases under different idle patterns and share totals.
// The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import gfsq_pkg::*;

  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 140;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES = 30;

  logic clk_i;
  logic rst_ni;

  gfsq_chan_if #(.payload_t(gfsq_req_t))          req_if ();
  gfsq_chan_if #(.payload_t(gfsq_rsp_t))          rsp_if ();
  gfsq_chan_if #(.payload_t(logic [SHARE_W-1:0])) cfg_if ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned created;
  int unsigned dispatched;
  int unsigned create_rejects;
  int unsigned empty_rejects;
  int unsigned send_idle;
  int unsigned recv_stall;
  int unsigned quiet_cycles;

  group_fair_share_ready_queue_unit u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_chan (req_if),
    .rsp_chan (rsp_if),
    .cfg_chan (cfg_if)
  );

  gfsq_share_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_if           (req_if),
    .rsp_if           (rsp_if),
    .cfg_if           (cfg_if),
    .errors_o         (mismatches),
    .pending_o        (pending),
    .created_o        (created),
    .dispatched_o     (dispatched),
    .create_rejects_o (create_rejects),
    .empty_rejects_o  (empty_rejects)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // Ends the run when no channel has moved an item for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic gfsq_req_t make_req(input req_type_e kind,
                                         input logic [GROUP_W-1:0] grp,
                                         input logic [PID_W-1:0] pid);
    gfsq_req_t r;
    r.req_type   = kind;
    r.group_id   = grp;
    r.process_id = pid;
    return r;
  endfunction

  // Valid stays high across back-to-back items and only drops for a gap.
  task automatic send_request(input gfsq_req_t item);
    if ($urandom_range(0, 99) < send_idle) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= item;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic drain_replies();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  task automatic write_share_total(input logic [SHARE_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    logic [GROUP_W-1:0] fill_groups [15];
    logic [SHARE_W-1:0] totals      [PHASES];
    int unsigned        idle_modes  [PHASES][2];
    int unsigned        create_bias;
    bit                 narrow;
    gfsq_req_t          item;

    fill_groups = '{4'd0, 4'd15, 4'd15, 4'd3, 4'd3, 4'd3, 4'd7, 4'd0,
                    4'd12, 4'd15, 4'd5, 4'd5, 4'd9, 4'd10, 4'd6};
    totals      = '{8'd255, 8'd1, 8'd0, 8'd3, 8'd100, 8'd37, 8'd200, 8'd0};
    totals[7]   = SHARE_W'($urandom_range(1, 254));
    idle_modes  = '{'{0, 0}, '{67, 0}, '{0, 67}, '{23, 23},
                    '{0, 0}, '{67, 0}, '{0, 67}, '{23, 23}};

    rst_ni       = 1'b0;
    send_idle    = 0;
    recv_stall   = 0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset share total: dispatch on an empty queue,
    // fill to capacity with id and group extremes, overfill, then drain half.
    send_request(make_req(REQ_DISPATCH, '1, '1));
    for (int i = 0; i < 15; i++) begin
      if (i == 0) item = make_req(REQ_CREATE, fill_groups[i], '0);
      else if (i == 1) item = make_req(REQ_CREATE, fill_groups[i], '1);
      else item = make_req(REQ_CREATE, fill_groups[i], PID_W'($urandom));
      send_request(item);
    end
    send_request(make_req(REQ_CREATE, 4'd8, 24'hA5A5A5));
    for (int i = 0; i < 8; i++) begin
      send_request(make_req(REQ_DISPATCH, GROUP_W'($urandom), PID_W'($urandom)));
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_replies();
      write_share_total(totals[p]);
      send_idle  = idle_modes[p][0];
      recv_stall = idle_modes[p][1];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Bursts lean toward filling or draining so the queue visits both
        // its empty and full states with mixed group populations.
        if (n % 16 == 0) begin
          create_bias = 25 * $urandom_range(1, 3);
          narrow      = $urandom_range(0, 1);
        end
        if (n == PHASE_ITEMS / 2) drain_replies();
        item = make_req(($urandom_range(0, 99) < create_bias) ? REQ_CREATE : REQ_DISPATCH,
                        narrow ? GROUP_W'($urandom_range(0, 3)) : GROUP_W'($urandom),
                        PID_W'($urandom));
        send_request(item);
      end
    end

    drain_replies();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Run covered %0d creates and %0d dispatches, with %0d creates refused",
             created, dispatched, create_rejects);
    $display("on a full queue and %0d dispatches on an empty one, share totals 0 to 255.",
             empty_rejects);
    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
